[src/four_channel_servo_slew_limiter_defines.svh]
// Assertion macros for the servo slew limiter.
`ifndef FOUR_CHANNEL_SERVO_SLEW_LIMITER_DEFINES_SVH
`define FOUR_CHANNEL_SERVO_SLEW_LIMITER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ssl_pkg.sv]
package ssl_pkg;

    localparam int NCH        = 4;
    localparam int CH_W       = 2;
    localparam int STEP_W     = 12;
    localparam int TV_W       = 12;
    localparam int PWM_W      = 12;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int PWM_OFFSET = 500;
    localparam int PWM_NUM    = 25;
    localparam int STEP_RESET = 32;

    localparam logic [NCH-1:0][7:0] RESET_DEG = {8'd45, 8'd90, 8'd25, 8'd90};

    typedef enum logic
    {
        CMD_SET_TARGET = 1'b0,
        CMD_TICK       = 1'b1
    } cmd_t;

    typedef enum logic [CH_W-1:0]
    {
        CH_BASE    = 2'd0,
        CH_ELBOW   = 2'd1,
        CH_WRIST   = 2'd2,
        CH_GRIPPER = 2'd3
    } ch_t;

    typedef struct packed
    {
        logic [PWM_W-1:0] pwm_base;
        logic [PWM_W-1:0] pwm_elbow;
        logic [PWM_W-1:0] pwm_wrist;
        logic [PWM_W-1:0] pwm_gripper;
        logic             all_at_target;
    } result_t;

endpackage

[src/four_channel_servo_slew_limiter.sv]
// Four-channel servo slew limiter. Each request either sets one channel's target angle
// (saturated to 180 degrees) or is a control tick that moves every channel toward its
// target by its step register, snapping inside half a degree and never overshooting.
// Every request returns the four PWM compare values and an all-at-target flag. Angles
// and targets live in a four-entry state RAM that one sweep reads, updates and writes
// back one channel per cycle. A new request is taken once the previous sweep reaches
// its last channel, and only while fewer than two requests await their result. Step
// registers sit on the APB port at byte addresses 0, 4, 8 and 12.
module four_channel_servo_slew_limiter
    import ssl_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [CH_W-1:0]   channel,
    input  logic [TV_W-1:0]   target_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PWM_W-1:0]  pwm_base,
    output logic [PWM_W-1:0]  pwm_elbow,
    output logic [PWM_W-1:0]  pwm_wrist,
    output logic [PWM_W-1:0]  pwm_gripper,
    output logic              all_at_target
);

    `include "four_channel_servo_slew_limiter_defines.svh"

    localparam int ONE_DEG   = 1 << ANGLE_FRAC_BITS;
    localparam int MAX_ANGLE = 180 * ONE_DEG;
    localparam int SNAP_BAND = ONE_DEG / 2;
    localparam int AT_BAND   = 3 * ONE_DEG / 2;
    localparam int AW        = $clog2(MAX_ANGLE + 1);
    localparam int DW        = (AW > STEP_W) ? AW : STEP_W;
    localparam int PROD_W    = AW + 5;
    localparam int ENT_W     = 2 * AW;

    logic [STEP_W-1:0] step_base_reg;
    logic [STEP_W-1:0] step_elbow_reg;
    logic [STEP_W-1:0] step_wrist_reg;
    logic [STEP_W-1:0] step_gripper_reg;
    logic              cfg_wr;
    ch_t               cfg_idx;

    logic              act_reg;
    logic [CH_W-1:0]   ph_reg;
    logic              cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [AW-1:0]     tv_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [NCH-1:0]    ent_valid_reg;

    logic              s2_valid_reg;
    logic              s2_last_reg;
    logic              s2_init_reg;
    logic [CH_W-1:0]   s2_ch_reg;
    logic              s2_cmd_reg;
    logic [CH_W-1:0]   s2_wch_reg;
    logic [AW-1:0]     s2_tv_reg;

    logic [PWM_W-1:0]  pwm_acc_reg [NCH];
    logic              all_acc_reg;

    result_t           out_reg;
    logic              out_valid_reg;
    result_t           hold_reg;
    logic              hold_valid_reg;

    logic              in_fire;
    logic              out_fire;
    logic              slot_free;
    logic [DW-1:0]     tv_ext;
    logic [AW-1:0]     tv_sat;

    logic [ENT_W-1:0]  ram_q;
    logic [ENT_W-1:0]  ram_d;
    logic [AW-1:0]     rst_ang;
    logic [AW-1:0]     cur;
    logic [AW-1:0]     tgt;
    logic [AW-1:0]     err;
    logic [STEP_W-1:0] step_sel;
    logic [DW-1:0]     step_lim;
    logic [AW-1:0]     cur_new;
    logic [AW-1:0]     tgt_new;
    logic [AW-1:0]     err_new;
    logic [PROD_W-1:0] prod;
    logic [PWM_W-1:0]  pwm_new;
    logic              at_ok;
    logic              done;
    result_t           res;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ch_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_base_reg    <= STEP_W'(STEP_RESET);
            step_elbow_reg   <= STEP_W'(STEP_RESET);
            step_wrist_reg   <= STEP_W'(STEP_RESET);
            step_gripper_reg <= STEP_W'(STEP_RESET);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CH_BASE:    step_base_reg    <= pwdata[STEP_W-1:0];
                CH_ELBOW:   step_elbow_reg   <= pwdata[STEP_W-1:0];
                CH_WRIST:   step_wrist_reg   <= pwdata[STEP_W-1:0];
                CH_GRIPPER: step_gripper_reg <= pwdata[STEP_W-1:0];
                default:    step_base_reg    <= step_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CH_BASE:    prdata = DATA_W'(step_base_reg);
            CH_ELBOW:   prdata = DATA_W'(step_elbow_reg);
            CH_WRIST:   prdata = DATA_W'(step_wrist_reg);
            CH_GRIPPER: prdata = DATA_W'(step_gripper_reg);
            default:    prdata = '0;
        endcase
    end

    // request intake and sweep sequencer
    assign slot_free = !act_reg || (ph_reg == CH_W'(CH_GRIPPER));
    assign in_ready  = slot_free && (cnt_reg < 2'd2);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign tv_ext    = DW'(target_value);
    assign tv_sat    = (tv_ext > DW'(MAX_ANGLE)) ? AW'(MAX_ANGLE) : AW'(tv_ext);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_fire && !out_fire)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!in_fire && out_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ph_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                act_reg <= 1'b1;
                ph_reg  <= '0;
            end
            else if (act_reg)
            begin
                act_reg <= (ph_reg != CH_W'(CH_GRIPPER));
                ph_reg  <= ph_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd;
            ch_reg  <= channel;
            tv_reg  <= tv_sat;
        end
    end

    // state RAM: {current, target} per channel
    ssl_ram
    #(
        .WIDTH (ENT_W),
        .DEPTH (NCH)
    )
    u_state_ram
    (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_ch_reg),
        .wdata (ram_d),
        .raddr (ph_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= act_reg;
            if (s2_valid_reg)
            begin
                ent_valid_reg[s2_ch_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= (ph_reg == CH_W'(CH_GRIPPER));
        s2_init_reg <= !ent_valid_reg[ph_reg];
        s2_ch_reg   <= ph_reg;
        s2_cmd_reg  <= cmd_reg;
        s2_wch_reg  <= ch_reg;
        s2_tv_reg   <= tv_reg;
    end

    // update one channel
    always_comb
    begin
        case (ch_t'(s2_ch_reg))
            CH_BASE:    step_sel = step_base_reg;
            CH_ELBOW:   step_sel = step_elbow_reg;
            CH_WRIST:   step_sel = step_wrist_reg;
            CH_GRIPPER: step_sel = step_gripper_reg;
            default:    step_sel = '0;
        endcase
    end

    assign rst_ang = AW'(RESET_DEG[s2_ch_reg] * ONE_DEG);
    assign cur     = s2_init_reg ? rst_ang : ram_q[ENT_W-1:AW];
    assign tgt     = s2_init_reg ? rst_ang : ram_q[AW-1:0];
    assign err     = (tgt > cur) ? (tgt - cur) : (cur - tgt);

    always_comb
    begin
        cur_new  = cur;
        tgt_new  = tgt;
        step_lim = DW'(step_sel);
        if (DW'(err) < step_lim)
        begin
            step_lim = DW'(err);
        end
        if (s2_cmd_reg == CMD_SET_TARGET)
        begin
            if (s2_wch_reg == s2_ch_reg)
            begin
                tgt_new = s2_tv_reg;
            end
        end
        else if (err < AW'(SNAP_BAND))
        begin
            cur_new = tgt;
        end
        else if (tgt > cur)
        begin
            cur_new = cur + AW'(step_lim);
        end
        else
        begin
            cur_new = cur - AW'(step_lim);
        end
    end

    assign ram_d   = {cur_new, tgt_new};
    assign err_new = (tgt_new > cur_new) ? (tgt_new - cur_new) : (cur_new - tgt_new);
    assign at_ok   = (DW'(err_new) < DW'(AT_BAND));
    assign prod    = PROD_W'(cur_new) * PROD_W'(PWM_NUM);
    assign pwm_new = PWM_W'(PWM_OFFSET) + PWM_W'(prod >> (ANGLE_FRAC_BITS + 1));

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            pwm_acc_reg[s2_ch_reg] <= pwm_new;
            all_acc_reg <= (s2_ch_reg == CH_W'(CH_BASE)) ? at_ok : (all_acc_reg && at_ok);
        end
    end

    assign done              = s2_valid_reg && s2_last_reg;
    assign res.pwm_base      = pwm_acc_reg[CH_BASE];
    assign res.pwm_elbow     = pwm_acc_reg[CH_ELBOW];
    assign res.pwm_wrist     = pwm_acc_reg[CH_WRIST];
    assign res.pwm_gripper   = pwm_new;
    assign res.all_at_target = all_acc_reg && at_ok;

    // output register with one hold slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            if (hold_valid_reg)
            begin
                hold_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= done;
            end
        end
        else if (done)
        begin
            if (out_valid_reg)
            begin
                hold_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            out_reg <= hold_valid_reg ? hold_reg : res;
        end
        else if (done)
        begin
            if (out_valid_reg)
            begin
                hold_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_base      = out_reg.pwm_base;
    assign pwm_elbow     = out_reg.pwm_elbow;
    assign pwm_wrist     = out_reg.pwm_wrist;
    assign pwm_gripper   = out_reg.pwm_gripper;
    assign all_at_target = out_reg.all_at_target;

    `SSL_ASSERT(a_cnt_bound, (cnt_reg != 2'd3), "request count out of range")
    `SSL_ASSERT(a_hold_order, (hold_valid_reg |-> out_valid_reg), "hold slot filled ahead of output")
    `SSL_ASSERT(a_sweep_start, (in_fire |=> (act_reg && ph_reg == CH_W'(CH_BASE))), "sweep did not start")
    `SSL_ASSERT(a_done_owned, (done |-> (cnt_reg != 2'd0)), "result with no request in flight")
    `SSL_ASSERT(a_hold_no_done, (hold_valid_reg |-> !done), "result completed with both slots full")

endmodule

[src/ssl_ram.sv]
module ssl_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
